// ----- sv/ecw_pkg.sv -----
// ---------------------------------------------------------------------------
// ecw_pkg
// Shared types, widths and the multiply-accumulate step table for the
// cotangent edge weight block.
// ---------------------------------------------------------------------------
package ecw_pkg;

  localparam int VERTEX_SLOTS_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int COORD_W     = 32;
  localparam int IDX_W       = 12;
  localparam int POS_W       = 3 * COORD_W;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 68;
  localparam int ACC_W       = 2 * PROD_W;
  localparam int ROOT_W      = ACC_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int Q_W         = COORD_W + 1;
  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 72;
  localparam int MAC_STEPS   = 12;
  localparam int STEP_W      = 4;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_P, S_RD_B, S_RD_W, S_MLD, S_MRUN, S_SQRT, S_DIV, S_FIN, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_D0, OP_D1, OP_D2, OP_E0, OP_E1, OP_E2, OP_C0, OP_C1, OP_C2
  } opnd_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_DOT, DST_C0, DST_C1, DST_C2, DST_S
  } dst_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  sub;
    logic  clr;
    dst_t  dst;
  } mac_step_t;

  // dot product, the three cross components, then the squared length
  function automatic mac_step_t mac_step(logic [STEP_W-1:0] k);
    mac_step_t s;
    case (k)
      4'd0:    s = '{OP_D0, OP_E0, 1'b0, 1'b1, DST_NONE};
      4'd1:    s = '{OP_D1, OP_E1, 1'b0, 1'b0, DST_NONE};
      4'd2:    s = '{OP_D2, OP_E2, 1'b0, 1'b0, DST_DOT};
      4'd3:    s = '{OP_D1, OP_E2, 1'b0, 1'b1, DST_NONE};
      4'd4:    s = '{OP_D2, OP_E1, 1'b1, 1'b0, DST_C0};
      4'd5:    s = '{OP_D2, OP_E0, 1'b0, 1'b1, DST_NONE};
      4'd6:    s = '{OP_D0, OP_E2, 1'b1, 1'b0, DST_C1};
      4'd7:    s = '{OP_D0, OP_E1, 1'b0, 1'b1, DST_NONE};
      4'd8:    s = '{OP_D1, OP_E0, 1'b1, 1'b0, DST_C2};
      4'd9:    s = '{OP_C0, OP_C0, 1'b0, 1'b1, DST_NONE};
      4'd10:   s = '{OP_C1, OP_C1, 1'b0, 1'b0, DST_NONE};
      4'd11:   s = '{OP_C2, OP_C2, 1'b0, 1'b0, DST_S};
      default: s = '{OP_D0, OP_E0, 1'b0, 1'b1, DST_NONE};
    endcase
    return s;
  endfunction

endpackage

// ----- sv/ecw_ram.sv -----
// ---------------------------------------------------------------------------
// ecw_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ecw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/edge_cotangent_weights_top.sv -----
// ---------------------------------------------------------------------------
// edge_cotangent_weights_top
// Vertex store plus bit-serial cotangent engine for mesh edge weights.
// ---------------------------------------------------------------------------
// A load transaction (tuser 0) writes one vertex position when its index is in
// range. An edge transaction (tuser 1) returns one result: for each opposite
// vertex the block reads three positions, runs twelve products through one
// bit-serial multiply-accumulate unit (each product is loaded, then shifted one
// multiplier bit at a time until no set bit is left, then closed), then runs a
// bit-serial square root and a restoring divide (skipped when the cross product
// is zero). An interior edge computes two cotangents; a boundary edge whose face
// holds neither opposite vertex goes straight to the done state. Items are
// worked one at a time; a finished result waits in the output register while
// the next item is taken.
module edge_cotangent_weights_top #(
  parameter int VERTEX_SLOTS = ecw_pkg::VERTEX_SLOTS_DEF,
  parameter int FRAC_BITS    = ecw_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // coord_x, coord_y, coord_z, end_a, far_left, end_b, far_right, on_boundary,
  // face_corner_1, face_corner_2, face_corner_3, zero pad
  input  logic [ecw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cot_first, cot_second, degenerate, no_match, zero pad
  output logic [ecw_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int AW    = $clog2(VERTEX_SLOTS);
  localparam int NW    = ecw_pkg::PROD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);
  localparam int CW    = ecw_pkg::COORD_W;
  localparam int IW    = ecw_pkg::IDX_W;
  localparam int PW    = ecw_pkg::PROD_W;
  localparam int ACW   = ecw_pkg::ACC_W;
  localparam int RW    = ecw_pkg::ROOT_W;
  localparam int REMW  = ecw_pkg::REM_W;
  localparam int QW    = ecw_pkg::Q_W;
  localparam int DW    = ecw_pkg::DIFF_W;

  ecw_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] a_r, a_nxt, b_r, b_nxt, fr_r, fr_nxt, p_r, p_nxt;
  logic          two_r, two_nxt, which_r, which_nxt;
  logic          rd_oor_r, rd_oor_nxt;
  logic [ecw_pkg::POS_W-1:0] pos_a_r, pos_a_nxt, pos_p_r, pos_p_nxt;
  logic signed [DW-1:0] d_r [3], d_nxt [3], e_r [3], e_nxt [3];
  logic signed [PW-1:0] dot_r, dot_nxt;
  logic signed [PW-1:0] c_r [3], c_nxt [3];
  logic [ACW-1:0]  acc_r, acc_nxt, mc_r, mc_nxt, sq_r, sq_nxt;
  logic [PW-1:0]   mlt_r, mlt_nxt;
  logic            mneg_r, mneg_nxt;
  logic [ecw_pkg::STEP_W-1:0] k_r, k_nxt;
  logic [REMW-1:0] rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic            ovf_r, ovf_nxt, zr_r, zr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   cot1_r, cot1_nxt, cot2_r, cot2_nxt;
  logic            degen_r, degen_nxt, nomatch_r, nomatch_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [ecw_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // input fields
  logic [CW-1:0] f_x, f_y, f_z;
  logic [IW-1:0] f_a, f_fl, f_b, f_fr, f_c1, f_c2, f_c3;
  logic          f_bnd;
  assign f_x   = in_tdata[31:0];
  assign f_y   = in_tdata[63:32];
  assign f_z   = in_tdata[95:64];
  assign f_a   = in_tdata[107:96];
  assign f_fl  = in_tdata[119:108];
  assign f_b   = in_tdata[131:120];
  assign f_fr  = in_tdata[143:132];
  assign f_bnd = in_tdata[144];
  assign f_c1  = in_tdata[156:145];
  assign f_c2  = in_tdata[168:157];
  assign f_c3  = in_tdata[180:169];

  logic in_acc;
  assign in_tready = (state_r == ecw_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // vertex store
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [ecw_pkg::POS_W-1:0] ram_rdata, rdata_m;
  logic [IW-1:0] rd_idx;

  assign ram_we = in_acc && !in_tuser && (32'(f_a) < VERTEX_SLOTS);

  always_comb begin
    case (state_r)
      ecw_pkg::S_RD_P: rd_idx = p_r;
      ecw_pkg::S_RD_B: rd_idx = b_r;
      default:         rd_idx = a_r;
    endcase
  end
  assign ram_raddr  = AW'(rd_idx);
  assign rd_oor_nxt = !(32'(rd_idx) < VERTEX_SLOTS);
  assign rdata_m    = rd_oor_r ? '0 : ram_rdata;

  ecw_ram #(
    .WIDTH (ecw_pkg::POS_W),
    .DEPTH (VERTEX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(f_a)),
    .wdata ({f_z, f_y, f_x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // operand selection for the multiply-accumulate unit
  ecw_pkg::mac_step_t stp;
  assign stp = ecw_pkg::mac_step(k_r);

  function automatic logic signed [PW-1:0] pick(ecw_pkg::opnd_t o,
      logic signed [DW-1:0] d0, logic signed [DW-1:0] d1, logic signed [DW-1:0] d2,
      logic signed [DW-1:0] e0, logic signed [DW-1:0] e1, logic signed [DW-1:0] e2,
      logic signed [PW-1:0] c0, logic signed [PW-1:0] c1, logic signed [PW-1:0] c2);
    logic signed [PW-1:0] v;
    case (o)
      ecw_pkg::OP_D0: v = PW'(d0);
      ecw_pkg::OP_D1: v = PW'(d1);
      ecw_pkg::OP_D2: v = PW'(d2);
      ecw_pkg::OP_E0: v = PW'(e0);
      ecw_pkg::OP_E1: v = PW'(e1);
      ecw_pkg::OP_E2: v = PW'(e2);
      ecw_pkg::OP_C0: v = c0;
      ecw_pkg::OP_C1: v = c1;
      ecw_pkg::OP_C2: v = c2;
      default:        v = '0;
    endcase
    return v;
  endfunction

  logic signed [PW-1:0] va, vb;
  logic [PW-1:0] mag_a, mag_b, mag_dot;
  assign va      = pick(stp.a, d_r[0], d_r[1], d_r[2], e_r[0], e_r[1], e_r[2],
                        c_r[0], c_r[1], c_r[2]);
  assign vb      = pick(stp.b, d_r[0], d_r[1], d_r[2], e_r[0], e_r[1], e_r[2],
                        c_r[0], c_r[1], c_r[2]);
  assign mag_a   = va[PW-1] ? PW'(-va) : PW'(va);
  assign mag_b   = vb[PW-1] ? PW'(-vb) : PW'(vb);
  assign mag_dot = dot_r[PW-1] ? PW'(-dot_r) : PW'(dot_r);

  // square root and divide datapath
  logic [REMW-1:0] sq_t, sq_trial, dv_t, dv_div;
  logic            sq_ge, dv_ge;
  assign sq_t     = {rem_r[REMW-3:0], sq_r[ACW-1 -: 2]};
  assign sq_trial = REMW'({root_r, 2'b01});
  assign sq_ge    = (sq_t >= sq_trial);
  assign dv_t     = {rem_r[REMW-2:0], sq_r[ACW-1]};
  assign dv_div   = REMW'(root_r);
  assign dv_ge    = (dv_t >= dv_div);

  logic [QW-1:0] lim, qs;
  logic [CW-1:0] cot_val;
  logic          dneg;
  assign dneg = dot_r[PW-1];
  assign lim  = dneg ? QW'(33'h1_0000_0000 >> 1) : QW'(33'h0_7FFF_FFFF);
  assign qs   = (ovf_r || (q_r > lim)) ? lim : q_r;

  always_comb begin
    if (zr_r) begin
      if (dot_r == '0) begin
        cot_val = '0;
      end else if (dneg) begin
        cot_val = 32'h8000_0000;
      end else begin
        cot_val = 32'h7FFF_FFFF;
      end
    end else if (dneg) begin
      cot_val = CW'(-qs);
    end else begin
      cot_val = qs[CW-1:0];
    end
  end

  // boundary face corner search
  logic hit_l, hit_r;
  assign hit_l = (f_c1 == f_fl) || (f_c2 == f_fl) || (f_c3 == f_fl);
  assign hit_r = (f_c1 == f_fr) || (f_c2 == f_fr) || (f_c3 == f_fr);

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    fr_nxt         = fr_r;
    p_nxt          = p_r;
    two_nxt        = two_r;
    which_nxt      = which_r;
    pos_a_nxt      = pos_a_r;
    pos_p_nxt      = pos_p_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    dot_nxt        = dot_r;
    c_nxt          = c_r;
    acc_nxt        = acc_r;
    mc_nxt         = mc_r;
    mlt_nxt        = mlt_r;
    mneg_nxt       = mneg_r;
    k_nxt          = k_r;
    sq_nxt         = sq_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    q_nxt          = q_r;
    ovf_nxt        = ovf_r;
    zr_nxt         = zr_r;
    cnt_nxt        = cnt_r;
    cot1_nxt       = cot1_r;
    cot2_nxt       = cot2_r;
    degen_nxt      = degen_r;
    nomatch_nxt    = nomatch_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ecw_pkg::S_IDLE: begin
        if (in_acc && in_tuser) begin
          a_nxt       = f_a;
          b_nxt       = f_b;
          fr_nxt      = f_fr;
          which_nxt   = 1'b0;
          cot1_nxt    = '0;
          cot2_nxt    = '0;
          degen_nxt   = 1'b0;
          nomatch_nxt = 1'b0;
          state_nxt   = ecw_pkg::S_RD_A;
          if (!f_bnd) begin
            p_nxt   = f_fl;
            two_nxt = 1'b1;
          end else begin
            two_nxt = 1'b0;
            if (hit_l) begin
              p_nxt = f_fl;
            end else if (hit_r) begin
              p_nxt = f_fr;
            end else begin
              nomatch_nxt = 1'b1;
              state_nxt   = ecw_pkg::S_DONE;
            end
          end
        end
      end
      ecw_pkg::S_RD_A: state_nxt = ecw_pkg::S_RD_P;
      ecw_pkg::S_RD_P: begin
        pos_a_nxt = rdata_m;
        state_nxt = ecw_pkg::S_RD_B;
      end
      ecw_pkg::S_RD_B: begin
        pos_p_nxt = rdata_m;
        state_nxt = ecw_pkg::S_RD_W;
      end
      ecw_pkg::S_RD_W: begin
        for (int i = 0; i < 3; i++) begin
          d_nxt[i] = DW'($signed(pos_a_r[i*CW +: CW])) - DW'($signed(pos_p_r[i*CW +: CW]));
          e_nxt[i] = DW'($signed(rdata_m[i*CW +: CW])) - DW'($signed(pos_p_r[i*CW +: CW]));
        end
        k_nxt     = '0;
        state_nxt = ecw_pkg::S_MLD;
      end
      ecw_pkg::S_MLD: begin
        mc_nxt   = ACW'(mag_a);
        mlt_nxt  = mag_b;
        mneg_nxt = va[PW-1] ^ vb[PW-1] ^ stp.sub;
        if (stp.clr) begin
          acc_nxt = '0;
        end
        state_nxt = ecw_pkg::S_MRUN;
      end
      ecw_pkg::S_MRUN: begin
        if (mlt_r == '0) begin
          case (stp.dst)
            ecw_pkg::DST_DOT: dot_nxt  = PW'(acc_r);
            ecw_pkg::DST_C0:  c_nxt[0] = PW'(acc_r);
            ecw_pkg::DST_C1:  c_nxt[1] = PW'(acc_r);
            ecw_pkg::DST_C2:  c_nxt[2] = PW'(acc_r);
            default: ;
          endcase
          if (k_r == ecw_pkg::STEP_W'(ecw_pkg::MAC_STEPS - 1)) begin
            sq_nxt    = acc_r;
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ecw_pkg::S_SQRT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ecw_pkg::S_MLD;
          end
        end else begin
          if (mlt_r[0]) begin
            acc_nxt = mneg_r ? acc_r - mc_r : acc_r + mc_r;
          end
          mc_nxt  = mc_r << 1;
          mlt_nxt = mlt_r >> 1;
        end
      end
      ecw_pkg::S_SQRT: begin
        // two radicand bits per cycle
        if (sq_ge) begin
          rem_nxt  = sq_t - sq_trial;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_t;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        sq_nxt  = sq_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RW - 1)) begin
          // load |dot| scaled up, top aligned, as the dividend
          sq_nxt    = ACW'({mag_dot, {FRAC_BITS{1'b0}}}) << (ACW - NW);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          zr_nxt    = 1'b0;
          state_nxt = ecw_pkg::S_DIV;
        end
      end
      ecw_pkg::S_DIV: begin
        if (root_r == '0) begin
          zr_nxt    = 1'b1;
          state_nxt = ecw_pkg::S_FIN;
        end else begin
          rem_nxt = dv_ge ? dv_t - dv_div : dv_t;
          q_nxt   = {q_r[QW-2:0], dv_ge};
          ovf_nxt = ovf_r | q_r[QW-1];
          sq_nxt  = sq_r << 1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NW - 1)) begin
            state_nxt = ecw_pkg::S_FIN;
          end
        end
      end
      ecw_pkg::S_FIN: begin
        if (zr_r) begin
          degen_nxt = 1'b1;
        end
        if (which_r) begin
          cot2_nxt = cot_val;
        end else begin
          cot1_nxt = cot_val;
        end
        if (!which_r && two_r) begin
          which_nxt = 1'b1;
          p_nxt     = fr_r;
          state_nxt = ecw_pkg::S_RD_A;
        end else begin
          state_nxt = ecw_pkg::S_DONE;
        end
      end
      ecw_pkg::S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'b0, nomatch_r, degen_r, cot2_r, cot1_r};
          state_nxt      = ecw_pkg::S_IDLE;
        end
      end
      default: state_nxt = ecw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ecw_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    fr_r        <= fr_nxt;
    p_r         <= p_nxt;
    two_r       <= two_nxt;
    which_r     <= which_nxt;
    rd_oor_r    <= rd_oor_nxt;
    pos_a_r     <= pos_a_nxt;
    pos_p_r     <= pos_p_nxt;
    d_r         <= d_nxt;
    e_r         <= e_nxt;
    dot_r       <= dot_nxt;
    c_r         <= c_nxt;
    acc_r       <= acc_nxt;
    mc_r        <= mc_nxt;
    mlt_r       <= mlt_nxt;
    mneg_r      <= mneg_nxt;
    k_r         <= k_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    q_r         <= q_nxt;
    ovf_r       <= ovf_nxt;
    zr_r        <= zr_nxt;
    cnt_r       <= cnt_nxt;
    cot1_r      <= cot1_nxt;
    cot2_r      <= cot2_nxt;
    degen_r     <= degen_nxt;
    nomatch_r   <= nomatch_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_load_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ecw_pkg::S_DONE)
    else $error("result raised outside the done state");

  a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ecw_pkg::S_IDLE)
    else $error("vertex write while an edge is in flight");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecw_pkg::S_DONE && nomatch_r) |-> (cot1_r == '0 && !degen_r))
    else $error("no-match result carries a cotangent");

  a_mult_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecw_pkg::S_MRUN && mlt_r != '0) |=> mlt_r == ($past(mlt_r) >> 1))
    else $error("serial multiplier lost a bit");

endmodule
